// ----- src/adsc_pkg.sv -----
// shared types, constants and the microprogram of the audio drift sample corrector
package adsc_pkg;

    // fixed-point defaults
    localparam int FRAC_BITS_DEF = 24;
    localparam int PC_W          = 5;

    // reciprocal of 25 scaled by 2^32, used for the divide by 100 after a shift by 2
    localparam logic [27:0] DIV25_RECIP = 28'd171798692;
    localparam logic [6:0]  PCT_MAX     = 7'd99;
    localparam logic [7:0]  PCT_BASE    = 8'd100;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_AUDIO_IS_MASTER    = 3'd0,
        REG_AVG_COEF           = 3'd1,
        REG_DIFF_THRESHOLD     = 3'd2,
        REG_NOSYNC_LIMIT       = 3'd3,
        REG_AVG_TARGET         = 3'd4,
        REG_CORRECTION_PERCENT = 3'd5,
        REG_SRC_RATE           = 3'd6
    } reg_idx_t;

    // reset values of the configuration registers
    localparam logic        RST_AUDIO_IS_MASTER    = 1'b0;
    localparam logic [15:0] RST_AVG_COEF           = 16'd52030;
    localparam logic [30:0] RST_DIFF_THRESHOLD     = 31'd335544;
    localparam logic [30:0] RST_NOSYNC_LIMIT       = 31'd167772160;
    localparam logic [5:0]  RST_AVG_TARGET         = 6'd20;
    localparam logic [6:0]  RST_CORRECTION_PERCENT = 7'd10;
    localparam logic [17:0] RST_SRC_RATE           = 18'd48000;

    // channel payloads
    typedef struct packed {
        logic signed [31:0] clock_diff;
        logic               diff_valid;
        logic [15:0]        sample_count;
    } frame_t;

    typedef struct packed {
        logic [16:0] wanted_count;
        logic        corrected;
    } result_t;

    typedef struct packed {
        reg_idx_t    index;
        logic [30:0] value;
    } cfg_t;

    // configuration register file contents
    typedef struct packed {
        logic        audio_is_master;
        logic [15:0] avg_coef;
        logic [30:0] diff_threshold;
        logic [30:0] nosync_limit;
        logic [5:0]  avg_target;
        logic [6:0]  correction_percent;
        logic [17:0] src_rate;
    } cfg_regs_t;

    // datapath micro-operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_MUL_ACC_LO,
        OP_MUL_ACC_HI,
        OP_ACC_UPD,
        OP_MUL_AVG_LO,
        OP_MUL_AVG_HI,
        OP_AVG_CMP,
        OP_MUL_CORR,
        OP_MUL_LO_BOUND,
        OP_MUL_HI_BOUND,
        OP_DIV_LO,
        OP_DIV_HI,
        OP_HI_STORE,
        OP_EMIT_CORR,
        OP_INC,
        OP_CLEAR,
        OP_EMIT_PASS
    } uop_t;

    // sequencer branch conditions
    typedef enum logic [2:0] {
        C_NEXT,
        C_JUMP,
        C_WAIT_IN,
        C_IF_MASTER,
        C_IF_NOSYNC,
        C_IF_COUNTING,
        C_IF_BELOW,
        C_WAIT_OUT
    } cond_t;

    typedef struct packed {
        uop_t             op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } uword_t;

    // program addresses
    localparam logic [PC_W-1:0] A_IDLE  = 5'd0;
    localparam logic [PC_W-1:0] A_INC   = 5'd16;
    localparam logic [PC_W-1:0] A_CLEAR = 5'd17;
    localparam logic [PC_W-1:0] A_PASS  = 5'd18;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic master;
        logic nosync;
        logic counting;
        logic below;
        logic out_busy;
    } status_t;

    // sequencer control to the datapath
    typedef struct packed {
        uop_t op;
        logic idle;
    } ctrl_t;

    // microprogram store
    function automatic uword_t ucode_rom(input logic [PC_W-1:0] addr);
        uword_t w;
        w = '{op: OP_NOP, cond: C_JUMP, target: A_IDLE};
        case (addr)
            5'd0:  w = '{op: OP_NOP,          cond: C_WAIT_IN,     target: A_IDLE};
            5'd1:  w = '{op: OP_NOP,          cond: C_IF_MASTER,   target: A_PASS};
            5'd2:  w = '{op: OP_NOP,          cond: C_IF_NOSYNC,   target: A_CLEAR};
            5'd3:  w = '{op: OP_MUL_ACC_LO,   cond: C_NEXT,        target: A_IDLE};
            5'd4:  w = '{op: OP_MUL_ACC_HI,   cond: C_NEXT,        target: A_IDLE};
            5'd5:  w = '{op: OP_ACC_UPD,      cond: C_IF_COUNTING, target: A_INC};
            5'd6:  w = '{op: OP_MUL_AVG_LO,   cond: C_NEXT,        target: A_IDLE};
            5'd7:  w = '{op: OP_MUL_AVG_HI,   cond: C_NEXT,        target: A_IDLE};
            5'd8:  w = '{op: OP_AVG_CMP,      cond: C_NEXT,        target: A_IDLE};
            5'd9:  w = '{op: OP_MUL_CORR,     cond: C_IF_BELOW,    target: A_PASS};
            5'd10: w = '{op: OP_MUL_LO_BOUND, cond: C_NEXT,        target: A_IDLE};
            5'd11: w = '{op: OP_MUL_HI_BOUND, cond: C_NEXT,        target: A_IDLE};
            5'd12: w = '{op: OP_DIV_LO,       cond: C_NEXT,        target: A_IDLE};
            5'd13: w = '{op: OP_DIV_HI,       cond: C_NEXT,        target: A_IDLE};
            5'd14: w = '{op: OP_HI_STORE,     cond: C_NEXT,        target: A_IDLE};
            5'd15: w = '{op: OP_EMIT_CORR,    cond: C_WAIT_OUT,    target: A_IDLE};
            5'd16: w = '{op: OP_INC,          cond: C_JUMP,        target: A_PASS};
            5'd17: w = '{op: OP_CLEAR,        cond: C_JUMP,        target: A_PASS};
            5'd18: w = '{op: OP_EMIT_PASS,    cond: C_WAIT_OUT,    target: A_IDLE};
            default: w = '{op: OP_NOP, cond: C_JUMP, target: A_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ----- src/adsc_stream_if.sv -----
// valid/ready channel carrying one payload item
interface adsc_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- src/adsc_useq.sv -----
// microprogram sequencer: step counter, control store and conditional jumps
module adsc_useq
(
    input  logic              clk,
    input  logic              rst_n,
    input  adsc_pkg::status_t status,
    output adsc_pkg::ctrl_t   ctrl
);

    logic [adsc_pkg::PC_W-1:0] pc_reg;
    logic [adsc_pkg::PC_W-1:0] pc_next;
    adsc_pkg::uword_t          word;

    // control store lookup
    assign word = adsc_pkg::ucode_rom(pc_reg);

    // next step selection
    always_comb
    begin
        pc_next = pc_reg + adsc_pkg::PC_W'(1);
        case (word.cond)
            adsc_pkg::C_NEXT:        pc_next = pc_reg + adsc_pkg::PC_W'(1);
            adsc_pkg::C_JUMP:        pc_next = word.target;
            adsc_pkg::C_WAIT_IN:     pc_next = status.in_valid ? pc_reg + adsc_pkg::PC_W'(1)
                                                               : pc_reg;
            adsc_pkg::C_IF_MASTER:   if (status.master) pc_next = word.target;
            adsc_pkg::C_IF_NOSYNC:   if (status.nosync) pc_next = word.target;
            adsc_pkg::C_IF_COUNTING: if (status.counting) pc_next = word.target;
            adsc_pkg::C_IF_BELOW:    if (status.below) pc_next = word.target;
            adsc_pkg::C_WAIT_OUT:    pc_next = status.out_busy ? pc_reg : word.target;
            default:                 pc_next = adsc_pkg::A_IDLE;
        endcase
    end

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= adsc_pkg::A_IDLE;
        else
            pc_reg <= pc_next;
    end

    // control outputs
    always_comb
    begin
        ctrl.op   = word.op;
        ctrl.idle = (pc_reg == adsc_pkg::A_IDLE);
    end

endmodule

// ----- src/adsc_datapath.sv -----
// datapath: item registers, shared multiplier, accumulator, bounds and result register
module adsc_datapath #(
    parameter int FRAC_BITS = adsc_pkg::FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  adsc_pkg::ctrl_t     ctrl,
    input  adsc_pkg::cfg_regs_t cfg_regs,
    input  adsc_pkg::frame_t    frame,
    input  logic                in_valid,
    input  logic                in_fire,
    input  logic                out_ready,
    output adsc_pkg::status_t   status,
    output adsc_pkg::result_t   result,
    output logic                out_valid
);

    localparam int CMAG_W = 49 - FRAC_BITS;
    localparam int SUM_W  = CMAG_W + 2;
    localparam logic signed [49:0] ACC_MAX_S = 50'sh7FFF_FFFF_FFFF;

    // item registers
    logic signed [31:0] diff_reg;
    logic               valid_reg;
    logic [15:0]        count_reg;

    // state and scratch registers
    logic signed [47:0] acc_reg, acc_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [59:0]        prod_reg, prod_next;
    logic [59:0]        t_reg, t_next;
    logic               ge_reg, ge_next;
    logic [CMAG_W-1:0]  cmag_reg, cmag_next;
    logic [23:0]        xlo_reg, xlo_next;
    logic [23:0]        xhi_reg, xhi_next;
    logic [16:0]        lo_reg, lo_next;
    logic [16:0]        hi_reg, hi_next;
    adsc_pkg::result_t  res_reg, res_next;
    logic               out_valid_reg, out_valid_next;

    // derived operands
    logic [47:0]        acc_abs;
    logic [46:0]        acc_mag;
    logic [31:0]        dmag;
    logic [16:0]        inv_coef;
    logic [6:0]         p_eff;
    logic [7:0]         lo_mul;
    logic [7:0]         hi_mul;
    logic [31:0]        mul_a;
    logic [27:0]        mul_b;
    logic [63:0]        full_prod;
    logic [47:0]        pmag;
    logic signed [49:0] pmag_s;
    logic signed [49:0] acc_sum;
    logic signed [SUM_W-1:0] cmag_s;
    logic signed [SUM_W-1:0] wanted_s;
    logic signed [SUM_W-1:0] lo_s;
    logic signed [SUM_W-1:0] hi_s;
    logic signed [SUM_W-1:0] wanted_clip;
    logic               out_busy;
    logic               emit;

    // magnitudes and percent limits
    assign acc_abs  = acc_reg[47] ? 48'(-acc_reg) : acc_reg;
    assign acc_mag  = acc_abs[46:0];
    assign dmag     = diff_reg[31] ? 32'(-diff_reg) : diff_reg;
    assign inv_coef = 17'h10000 - {1'b0, cfg_regs.avg_coef};
    assign p_eff    = (cfg_regs.correction_percent > adsc_pkg::PCT_MAX) ? adsc_pkg::PCT_MAX
                                                                        : cfg_regs.correction_percent;
    assign lo_mul   = adsc_pkg::PCT_BASE - {1'b0, p_eff};
    assign hi_mul   = adsc_pkg::PCT_BASE + {1'b0, p_eff};

    // two partial products of a 47-bit magnitude recombined, then scaled by 2^-16
    assign full_prod = t_reg[63-24:0] + {prod_reg[39:0], 24'b0};
    assign pmag      = full_prod[63:16];
    assign pmag_s    = $signed({2'b00, pmag});
    assign acc_sum   = 50'(diff_reg) + (acc_reg[47] ? -pmag_s : pmag_s);

    // corrected count before and after clipping
    assign cmag_s   = $signed({2'b00, cmag_reg});
    assign wanted_s = $signed(SUM_W'(count_reg)) + (diff_reg[31] ? -cmag_s : cmag_s);
    assign lo_s     = $signed(SUM_W'(lo_reg));
    assign hi_s     = $signed(SUM_W'(hi_reg));

    always_comb
    begin
        wanted_clip = wanted_s;
        if (wanted_clip < lo_s)
            wanted_clip = lo_s;
        if (wanted_clip > hi_s)
            wanted_clip = hi_s;
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.op)
            adsc_pkg::OP_MUL_ACC_LO:
            begin
                mul_a = {8'b0, acc_mag[23:0]};
                mul_b = {12'b0, cfg_regs.avg_coef};
            end
            adsc_pkg::OP_MUL_ACC_HI:
            begin
                mul_a = {9'b0, acc_mag[46:24]};
                mul_b = {12'b0, cfg_regs.avg_coef};
            end
            adsc_pkg::OP_MUL_AVG_LO:
            begin
                mul_a = {8'b0, acc_mag[23:0]};
                mul_b = {11'b0, inv_coef};
            end
            adsc_pkg::OP_MUL_AVG_HI:
            begin
                mul_a = {9'b0, acc_mag[46:24]};
                mul_b = {11'b0, inv_coef};
            end
            adsc_pkg::OP_MUL_CORR:
            begin
                mul_a = dmag;
                mul_b = {10'b0, cfg_regs.src_rate};
            end
            adsc_pkg::OP_MUL_LO_BOUND:
            begin
                mul_a = {16'b0, count_reg};
                mul_b = {20'b0, lo_mul};
            end
            adsc_pkg::OP_MUL_HI_BOUND:
            begin
                mul_a = {16'b0, count_reg};
                mul_b = {20'b0, hi_mul};
            end
            adsc_pkg::OP_DIV_LO:
            begin
                mul_a = {10'b0, xlo_reg[23:2]};
                mul_b = adsc_pkg::DIV25_RECIP;
            end
            adsc_pkg::OP_DIV_HI:
            begin
                mul_a = {10'b0, xhi_reg[23:2]};
                mul_b = adsc_pkg::DIV25_RECIP;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign out_busy = out_valid_reg && !out_ready;
    assign emit     = !out_busy && (ctrl.op == adsc_pkg::OP_EMIT_CORR ||
                                    ctrl.op == adsc_pkg::OP_EMIT_PASS);

    // micro-operation execution
    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        prod_next      = {28'b0, mul_a} * {32'b0, mul_b};
        t_next         = t_reg;
        ge_next        = ge_reg;
        cmag_next      = cmag_reg;
        xlo_next       = xlo_reg;
        xhi_next       = xhi_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (ctrl.op)
            adsc_pkg::OP_MUL_ACC_HI,
            adsc_pkg::OP_MUL_AVG_HI:
                t_next = prod_reg;
            adsc_pkg::OP_ACC_UPD:
            begin
                if (acc_sum > ACC_MAX_S)
                    acc_next = ACC_MAX_S[47:0];
                else if (acc_sum < -ACC_MAX_S)
                    acc_next = 48'(-ACC_MAX_S);
                else
                    acc_next = acc_sum[47:0];
            end
            adsc_pkg::OP_AVG_CMP:
                ge_next = (pmag >= {17'b0, cfg_regs.diff_threshold});
            adsc_pkg::OP_MUL_LO_BOUND:
                cmag_next = prod_reg[48:FRAC_BITS];
            adsc_pkg::OP_MUL_HI_BOUND:
                xlo_next = prod_reg[23:0];
            adsc_pkg::OP_DIV_LO:
                xhi_next = prod_reg[23:0];
            adsc_pkg::OP_DIV_HI:
                lo_next = prod_reg[48:32];
            adsc_pkg::OP_HI_STORE:
                hi_next = prod_reg[48:32];
            adsc_pkg::OP_EMIT_CORR:
            begin
                if (emit)
                begin
                    res_next       = '{wanted_count: wanted_clip[16:0], corrected: 1'b1};
                    out_valid_next = 1'b1;
                end
            end
            adsc_pkg::OP_EMIT_PASS:
            begin
                if (emit)
                begin
                    res_next       = '{wanted_count: {1'b0, count_reg}, corrected: 1'b0};
                    out_valid_next = 1'b1;
                end
            end
            adsc_pkg::OP_INC:
                cnt_next = cnt_reg + 6'd1;
            adsc_pkg::OP_CLEAR:
            begin
                acc_next = '0;
                cnt_next = '0;
            end
            default:
                ;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload and scratch registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            diff_reg  <= frame.clock_diff;
            valid_reg <= frame.diff_valid;
            count_reg <= frame.sample_count;
        end
        prod_reg <= prod_next;
        t_reg    <= t_next;
        ge_reg   <= ge_next;
        cmag_reg <= cmag_next;
        xlo_reg  <= xlo_next;
        xhi_reg  <= xhi_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        res_reg  <= res_next;
    end

    // status to the sequencer
    always_comb
    begin
        status.in_valid = in_valid;
        status.master   = cfg_regs.audio_is_master;
        status.nosync   = !valid_reg || (dmag >= {1'b0, cfg_regs.nosync_limit});
        status.counting = (cnt_reg < cfg_regs.avg_target);
        status.below    = !ge_reg;
        status.out_busy = out_busy;
    end

    assign result    = res_reg;
    assign out_valid = out_valid_reg;

endmodule

// ----- src/audio_drift_sample_corrector.sv -----
// A frame is taken only while the sequencer is idle. Its result is registered at an emit step,
// reached soonest when audio is master, then when the average is cleared, while averaging and
// below the threshold, and last on the correction path; emit waits while a result is unread.
// The next frame is taken only after the result is stored and the sequencer is back in idle,
// as set by the microprogram around the single shared 32x28 multiplier.
// Reset (rst_n low, asynchronous) clears the averaging state, step counter and result valid.
module audio_drift_sample_corrector #(
    parameter int FRAC_BITS = adsc_pkg::FRAC_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    adsc_stream_if.sink   frames,
    adsc_stream_if.source results,
    adsc_stream_if.sink   cfg
);

    adsc_pkg::cfg_regs_t cfg_regs_reg;
    adsc_pkg::cfg_regs_t cfg_regs_next;
    adsc_pkg::status_t   status;
    adsc_pkg::ctrl_t     ctrl;
    adsc_pkg::result_t   result;
    logic                out_valid;
    logic                in_fire;
    logic                cfg_fire;

    // handshakes
    assign frames.ready = ctrl.idle;
    assign in_fire      = frames.valid && frames.ready;
    assign cfg.ready    = 1'b1;
    assign cfg_fire     = cfg.valid && cfg.ready;

    // register file writes
    always_comb
    begin
        cfg_regs_next = cfg_regs_reg;
        if (cfg_fire)
        begin
            case (cfg.data.index)
                adsc_pkg::REG_AUDIO_IS_MASTER:
                    cfg_regs_next.audio_is_master = cfg.data.value[0];
                adsc_pkg::REG_AVG_COEF:
                    cfg_regs_next.avg_coef = cfg.data.value[15:0];
                adsc_pkg::REG_DIFF_THRESHOLD:
                    cfg_regs_next.diff_threshold = cfg.data.value;
                adsc_pkg::REG_NOSYNC_LIMIT:
                    cfg_regs_next.nosync_limit = cfg.data.value;
                adsc_pkg::REG_AVG_TARGET:
                    cfg_regs_next.avg_target = cfg.data.value[5:0];
                adsc_pkg::REG_CORRECTION_PERCENT:
                    cfg_regs_next.correction_percent = cfg.data.value[6:0];
                adsc_pkg::REG_SRC_RATE:
                    cfg_regs_next.src_rate = cfg.data.value[17:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_regs_reg.audio_is_master    <= adsc_pkg::RST_AUDIO_IS_MASTER;
            cfg_regs_reg.avg_coef           <= adsc_pkg::RST_AVG_COEF;
            cfg_regs_reg.diff_threshold     <= adsc_pkg::RST_DIFF_THRESHOLD;
            cfg_regs_reg.nosync_limit       <= adsc_pkg::RST_NOSYNC_LIMIT;
            cfg_regs_reg.avg_target         <= adsc_pkg::RST_AVG_TARGET;
            cfg_regs_reg.correction_percent <= adsc_pkg::RST_CORRECTION_PERCENT;
            cfg_regs_reg.src_rate           <= adsc_pkg::RST_SRC_RATE;
        end
        else
        begin
            cfg_regs_reg <= cfg_regs_next;
        end
    end

    // sequencer
    adsc_useq u_useq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    // datapath
    adsc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .cfg_regs  (cfg_regs_reg),
        .frame     (frames.data),
        .in_valid  (frames.valid),
        .in_fire   (in_fire),
        .out_ready (results.ready),
        .status    (status),
        .result    (result),
        .out_valid (out_valid)
    );

    assign results.valid = out_valid;
    assign results.data  = result;

    // an accepted frame takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !frames.ready)
        else $error("frame accepted while sequencer stays idle");

    // an uncorrected count is the 16-bit input count
    a_pass_width: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.data.corrected) |-> (results.data.wanted_count[16] == 1'b0))
        else $error("pass-through count exceeds input range");

    // a new result appears only after an emit step
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> ($past(ctrl.op) == adsc_pkg::OP_EMIT_CORR ||
                                  $past(ctrl.op) == adsc_pkg::OP_EMIT_PASS))
        else $error("result valid without emit step");

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the audio drift sample corrector
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     FRAC          = adsc_pkg::FRAC_BITS_DEF;
    localparam longint ACC_LIMIT     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam int     RANDOM_PHASES = 10;
    localparam int     PHASE_FRAMES  = 200;
    localparam int     END_SLACK     = 24;
    localparam int     STALL_LIMIT   = 4000;

    logic clk;
    logic rst_n;

    adsc_stream_if #(.T(adsc_pkg::frame_t))  frames_if ();
    adsc_stream_if #(.T(adsc_pkg::result_t)) results_if ();
    adsc_stream_if #(.T(adsc_pkg::cfg_t))    cfg_if ();

    audio_drift_sample_corrector #(.FRAC_BITS(FRAC)) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .frames  (frames_if),
        .results (results_if),
        .cfg     (cfg_if)
    );

    // register shadow and averaging state of the predictor
    adsc_pkg::cfg_regs_t regs = '{
        audio_is_master:    adsc_pkg::RST_AUDIO_IS_MASTER,
        avg_coef:           adsc_pkg::RST_AVG_COEF,
        diff_threshold:     adsc_pkg::RST_DIFF_THRESHOLD,
        nosync_limit:       adsc_pkg::RST_NOSYNC_LIMIT,
        avg_target:         adsc_pkg::RST_AVG_TARGET,
        correction_percent: adsc_pkg::RST_CORRECTION_PERCENT,
        src_rate:           adsc_pkg::RST_SRC_RATE
    };
    longint      drift_acc  = 0;
    logic [5:0]  avg_frames = '0;

    adsc_pkg::frame_t  frame_q[$];
    adsc_pkg::result_t wanted_q[$];

    int unsigned frames_queued    = 0;
    int unsigned frames_accepted  = 0;
    int unsigned results_checked  = 0;
    int unsigned corrections_seen = 0;
    int unsigned settings_used    = 0;
    int unsigned error_count      = 0;

    // sender burst state
    int unsigned burst_left;
    int unsigned gap_left;

    // receiver stall pattern state
    int unsigned stall_mode;
    int unsigned stall_left;
    int unsigned stall_tick;

    int unsigned idle_cycles;

    // expected count and correction flag for one frame, advances the averaging state
    function automatic adsc_pkg::result_t predict_wanted_count(input adsc_pkg::frame_t fr);
        longint            diff;
        longint            prod;
        longint            sum;
        longint            delta;
        longint            lo;
        longint            hi;
        longint            wanted;
        logic [63:0]       dmag;
        logic [63:0]       amag;
        logic [63:0]       pmag;
        logic [63:0]       avg;
        logic [63:0]       cmag;
        logic [63:0]       count;
        logic [6:0]        pct;
        adsc_pkg::result_t res;
        diff   = longint'($signed(fr.clock_diff));
        count  = {48'd0, fr.sample_count};
        wanted = longint'(count);
        res.corrected = 1'b0;
        if (!regs.audio_is_master)
        begin
            dmag = (diff < 0) ? -diff : diff;
            if (fr.diff_valid && dmag < {33'd0, regs.nosync_limit})
            begin
                // exponential average, product truncated toward zero, sum saturated
                amag = (drift_acc < 0) ? -drift_acc : drift_acc;
                pmag = (amag * {48'd0, regs.avg_coef}) >> 16;
                prod = (drift_acc < 0) ? -longint'(pmag) : longint'(pmag);
                sum  = diff + prod;
                if (sum > ACC_LIMIT)
                    sum = ACC_LIMIT;
                if (sum < -ACC_LIMIT)
                    sum = -ACC_LIMIT;
                drift_acc = sum;
                if (avg_frames < regs.avg_target)
                    avg_frames = avg_frames + 6'd1;
                else
                begin
                    amag = (drift_acc < 0) ? -drift_acc : drift_acc;
                    avg  = (amag * (64'd65536 - {48'd0, regs.avg_coef})) >> 16;
                    if (avg >= {33'd0, regs.diff_threshold})
                    begin
                        // shift by diff*rate, clipped to the allowed percentage
                        pct   = (regs.correction_percent > adsc_pkg::PCT_MAX)
                                ? adsc_pkg::PCT_MAX : regs.correction_percent;
                        cmag  = (dmag * {46'd0, regs.src_rate}) >> FRAC;
                        delta = (diff < 0) ? -longint'(cmag) : longint'(cmag);
                        lo    = longint'((count * (64'd100 - {57'd0, pct})) / 64'd100);
                        hi    = longint'((count * (64'd100 + {57'd0, pct})) / 64'd100);
                        wanted = longint'(count) + delta;
                        if (wanted < lo)
                            wanted = lo;
                        if (wanted > hi)
                            wanted = hi;
                        res.corrected = 1'b1;
                    end
                end
            end
            else
            begin
                drift_acc  = 0;
                avg_frames = '0;
            end
        end
        res.wanted_count = 17'(wanted);
        return res;
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // frame driver: bursts of random length separated by random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_if.valid <= 1'b0;
            frames_if.data  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (frames_if.valid && frames_if.ready)
            begin
                wanted_q.push_back(predict_wanted_count(frames_if.data));
                frames_accepted++;
            end
            if (!frames_if.valid || frames_if.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    frames_if.valid <= 1'b0;
                end
                else if (frame_q.size() == 0)
                    frames_if.valid <= 1'b0;
                else
                begin
                    frames_if.valid <= 1'b1;
                    frames_if.data  <= frame_q.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 32);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    // result monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        adsc_pkg::result_t want;
        logic              next_ready;
        if (!rst_n)
        begin
            results_if.ready <= 1'b0;
            stall_mode = 0;
            stall_left = 0;
            stall_tick = 0;
        end
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                results_checked++;
                if (results_if.data.corrected)
                    corrections_seen++;
                if (wanted_q.size() == 0)
                begin
                    $error("result with no frame pending: wanted_count %0d corrected %0d",
                           results_if.data.wanted_count, results_if.data.corrected);
                    error_count++;
                end
                else
                begin
                    want = wanted_q.pop_front();
                    if (results_if.data.wanted_count !== want.wanted_count)
                    begin
                        $error("wanted_count mismatch: expected %0d, actual %0d",
                               want.wanted_count, results_if.data.wanted_count);
                        error_count++;
                    end
                    if (results_if.data.corrected !== want.corrected)
                    begin
                        $error("corrected mismatch: expected %0d, actual %0d",
                               want.corrected, results_if.data.corrected);
                        error_count++;
                    end
                end
            end
            // switch stall pattern when its random run length runs out
            if (stall_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            else
                stall_left--;
            stall_tick++;
            case (stall_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = ($urandom_range(0, 1) == 1);
                2:       next_ready = ($urandom_range(0, 3) == 0);
                default: next_ready = (stall_tick % 5) != 4;
            endcase
            results_if.ready <= next_ready;
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles = 0;
        else if ((frames_if.valid && frames_if.ready) || (results_if.valid && results_if.ready)
                 || (cfg_if.valid && cfg_if.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                         idle_cycles, wanted_q.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // one register write, shadow updated at the handshake
    task automatic write_reg(input adsc_pkg::reg_idx_t idx, input logic [30:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{index: idx, value: val};
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        case (idx)
            adsc_pkg::REG_AUDIO_IS_MASTER:    regs.audio_is_master    = val[0];
            adsc_pkg::REG_AVG_COEF:           regs.avg_coef           = val[15:0];
            adsc_pkg::REG_DIFF_THRESHOLD:     regs.diff_threshold     = val;
            adsc_pkg::REG_NOSYNC_LIMIT:       regs.nosync_limit       = val;
            adsc_pkg::REG_AVG_TARGET:         regs.avg_target         = val[5:0];
            adsc_pkg::REG_CORRECTION_PERCENT: regs.correction_percent = val[6:0];
            adsc_pkg::REG_SRC_RATE:           regs.src_rate           = val[17:0];
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic master, input logic [15:0] coef,
                                  input logic [30:0] thr, input logic [30:0] lim,
                                  input logic [5:0] tgt, input logic [6:0] pct,
                                  input logic [17:0] rate);
        write_reg(adsc_pkg::REG_AUDIO_IS_MASTER, {30'd0, master});
        write_reg(adsc_pkg::REG_AVG_COEF, {15'd0, coef});
        write_reg(adsc_pkg::REG_DIFF_THRESHOLD, thr);
        write_reg(adsc_pkg::REG_NOSYNC_LIMIT, lim);
        write_reg(adsc_pkg::REG_AVG_TARGET, {25'd0, tgt});
        write_reg(adsc_pkg::REG_CORRECTION_PERCENT, {24'd0, pct});
        write_reg(adsc_pkg::REG_SRC_RATE, {13'd0, rate});
        settings_used++;
    endtask

    task automatic push_frame(input logic signed [31:0] diff, input logic ok,
                              input logic [15:0] count);
        frame_q.push_back('{clock_diff: diff, diff_valid: ok, sample_count: count});
        frames_queued++;
    endtask

    // all queued frames accepted and every result back
    task automatic wait_drained();
        while (frames_accepted != frames_queued || wanted_q.size() != 0)
            @(posedge clk);
    endtask

    // one random phase: random settings, mostly steady drift with random content
    task automatic run_random_phase();
        logic               master;
        logic [15:0]        coef;
        logic [30:0]        thr;
        logic [30:0]        lim;
        logic [5:0]         tgt;
        logic [6:0]         pct;
        logic [17:0]        rate;
        int                 base;
        int                 jitter;
        logic signed [31:0] diff;
        logic               ok;
        logic [15:0]        count;
        master = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 3))
            0:       coef = 16'd0;
            1:       coef = 16'hFFFF;
            2:       coef = adsc_pkg::RST_AVG_COEF;
            default: coef = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0:       thr = 31'd0;
            1:       thr = 31'h7FFF_FFFF;
            2:       thr = 31'($urandom_range(0, 1 << 20));
            default: thr = 31'($urandom_range(100000, 2000000));
        endcase
        case ($urandom_range(0, 9))
            0:       lim = 31'd0;
            1, 2:    lim = 31'h7FFF_FFFF;
            3:       lim = 31'($urandom);
            4, 5:    lim = 31'($urandom_range(1 << 20, 1 << 26));
            default: lim = adsc_pkg::RST_NOSYNC_LIMIT;
        endcase
        case ($urandom_range(0, 4))
            0:       tgt = 6'd0;
            1:       tgt = 6'd63;
            2:       tgt = 6'd1;
            default: tgt = 6'($urandom_range(1, 30));
        endcase
        case ($urandom_range(0, 4))
            0:       pct = 7'd0;
            1:       pct = 7'd99;
            2:       pct = 7'($urandom_range(100, 127));
            default: pct = 7'($urandom_range(1, 99));
        endcase
        case ($urandom_range(0, 7))
            0:       rate = 18'd0;
            1:       rate = 18'd192000;
            2:       rate = 18'd1;
            default: rate = 18'($urandom_range(8000, 192000));
        endcase
        write_settings(master, coef, thr, lim, tgt, pct, rate);

        base   = $urandom_range(0, 4000000);
        base   = $urandom_range(0, 1) ? -base : base;
        jitter = $urandom_range(0, 500000);
        for (int i = 0; i < PHASE_FRAMES; i++)
        begin
            ok = 1'b1;
            case ($urandom_range(0, 19))
                0:
                begin
                    ok   = 1'b0;
                    diff = $urandom;
                end
                1, 2:    diff = $urandom;
                3:       diff = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                default: diff = base + int'($urandom_range(0, 2 * jitter)) - jitter;
            endcase
            case ($urandom_range(0, 9))
                0:       count = 16'd0;
                1:       count = 16'hFFFF;
                2:       count = 16'($urandom);
                default: count = 16'($urandom_range(64, 4096));
            endcase
            push_frame(diff, ok, count);
        end
        wait_drained();
    endtask

    // stimulus
    initial
    begin
        rst_n        = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // no averaging, corrections from the first frame, widest clip
        write_settings(1'b0, 16'd0, 31'd0, 31'h7FFF_FFFF, 6'd0, 7'd99, 18'd192000);
        push_frame(32'sd0, 1'b1, 16'd1000);
        push_frame(32'sh7FFF_FFFF, 1'b1, 16'hFFFF);
        push_frame(32'sh8000_0001, 1'b1, 16'hFFFF);
        push_frame(32'sh8000_0000, 1'b1, 16'd1000);
        push_frame(32'sd16777, 1'b1, 16'd1000);
        push_frame(-32'sd16777, 1'b1, 16'd1000);
        push_frame(32'sd16777, 1'b1, 16'd0);
        push_frame(32'sd5000, 1'b0, 16'd300);
        wait_drained();

        // audio is master: counts pass through
        write_settings(1'b1, adsc_pkg::RST_AVG_COEF, adsc_pkg::RST_DIFF_THRESHOLD,
                       adsc_pkg::RST_NOSYNC_LIMIT, adsc_pkg::RST_AVG_TARGET,
                       adsc_pkg::RST_CORRECTION_PERCENT, adsc_pkg::RST_SRC_RATE);
        push_frame(32'sh7FFF_FFFF, 1'b1, 16'hFFFF);
        push_frame(32'sh8000_0000, 1'b0, 16'd0);
        push_frame(32'sd123456, 1'b1, 16'd480);
        wait_drained();

        // largest coefficient, percent above the cap, zero rate, short averaging
        write_settings(1'b0, 16'hFFFF, 31'd0, 31'h7FFF_FFFF, 6'd2, 7'd127, 18'd0);
        push_frame(32'sd838860, 1'b1, 16'd1024);
        push_frame(32'sd838860, 1'b1, 16'd1024);
        push_frame(32'sd838860, 1'b1, 16'd1024);
        push_frame(32'sd838860, 1'b0, 16'd1024);
        push_frame(-32'sd838860, 1'b1, 16'd2048);
        wait_drained();

        // averaged difference below the largest threshold, no clip room
        write_settings(1'b0, 16'd32768, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 6'd1, 7'd0, 18'd192000);
        push_frame(32'sd16777216, 1'b1, 16'd512);
        push_frame(32'sd16777216, 1'b1, 16'd512);
        wait_drained();

        // zero sync limit rejects everything, longest averaging target
        write_settings(1'b0, adsc_pkg::RST_AVG_COEF, adsc_pkg::RST_DIFF_THRESHOLD, 31'd0,
                       6'd63, 7'd10, 18'd1);
        push_frame(32'sd0, 1'b1, 16'd100);
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++)
            run_random_phase();

        wait_drained();
        repeat (END_SLACK) @(posedge clk);
        if (wanted_q.size() != 0)
        begin
            $error("%0d expected results never arrived", wanted_q.size());
            error_count++;
        end
        $display("checked %0d results for %0d frames under %0d register settings",
                 results_checked, frames_accepted, settings_used);
        $display("%0d frames had their sample count corrected", corrections_seen);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
